// ===== rtl/ptc_pkg.sv =====
// Shared constants and types for the pressure and temperature compensation core.
package ptc_pkg;

  localparam int DIV_W = 64;
  localparam int DVS_W = 31;

  localparam logic [1:0] REG_TEMP_COEF = 2'd0;
  localparam logic [1:0] REG_PRES_LOW  = 2'd1;
  localparam logic [1:0] REG_PRES_HIGH = 2'd2;
  localparam logic [1:0] REG_PRES_NINE = 2'd3;

  typedef struct packed {
    logic signed [15:0] tout;
    logic               zero;
    logic               neg;
  } side_t;

endpackage

// ===== rtl/ptc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ptc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [ptc_pkg::DIV_W-1:0]   in_dvd,
  input  logic [ptc_pkg::DVS_W-1:0]   in_dvs,
  input  ptc_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [ptc_pkg::DIV_W-1:0]   out_quo,
  output ptc_pkg::side_t              out_side
);
  import ptc_pkg::*;

  logic [DIV_W-1:0] vld_r;
  logic [DIV_W-1:0] dq_r   [DIV_W];
  logic [DVS_W-1:0] rem_r  [DIV_W];
  logic [DVS_W-1:0] dvs_r  [DIV_W];
  side_t            side_r [DIV_W];

  logic [DIV_W-1:0] dq_src   [DIV_W];
  logic [DVS_W-1:0] rem_src  [DIV_W];
  logic [DVS_W-1:0] dvs_src  [DIV_W];
  side_t            side_src [DIV_W];
  logic [DIV_W-1:0] dq_nxt   [DIV_W];
  logic [DVS_W-1:0] rem_nxt  [DIV_W];

  always_comb begin
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;
    rem_src[0]  = '0;
    dq_src[0]   = in_dvd;
    dvs_src[0]  = in_dvs;
    side_src[0] = in_side;
    for (int k = 1; k < DIV_W; k++) begin
      rem_src[k]  = rem_r[k-1];
      dq_src[k]   = dq_r[k-1];
      dvs_src[k]  = dvs_r[k-1];
      side_src[k] = side_r[k-1];
    end
    for (int k = 0; k < DIV_W; k++) begin
      trial      = {rem_src[k], dq_src[k][DIV_W-1]};
      diff       = trial - {1'b0, dvs_src[k]};
      ge         = (trial >= {1'b0, dvs_src[k]});
      rem_nxt[k] = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq_nxt[k]  = {dq_src[k][DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        dq_r[k]   <= dq_nxt[k];
        dvs_r[k]  <= dvs_src[k];
        side_r[k] <= side_src[k];
      end
    end
  end

  assign out_vld  = vld_r[DIV_W-1];
  assign out_quo  = dq_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

// ===== rtl/pressure_temperature_compensation_core.sv =====
// Top level of the pressure and temperature compensation core.
//
//  port group  dir  handshake            payload
//  in_         in   in_valid/in_ready    raw_temperature, raw_pressure
//  out_        out  out_valid/out_ready  temperature_centi, pressure_q24_8, divide_error
//  cfg_        in   cfg_we               cfg_index, cfg_wdata
//
//  One item enters per cycle while the output is not stalled; from accept to out_valid an item
//  passes 12 front stages, 64 divider stages, 6 back stages and one output register.
//  The 64-stage restoring divider sets the depth; each stage resolves one quotient bit.
//  rst_n clears all valid bits and the coefficients; payload registers are not reset.
//  A stalled output freezes the whole pipeline in place; no item is dropped or repeated.
module pressure_temperature_compensation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_raw_temperature,
  input  logic [19:0] in_raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_temperature_centi,
  output logic [31:0] out_pressure_q24_8,
  output logic        out_divide_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import ptc_pkg::*;

  logic [47:0] tcoef_r;
  logic [63:0] plow_r;
  logic [63:0] phigh_r;
  logic [15:0] p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcoef_r <= '0;
      plow_r  <= '0;
      phigh_r <= '0;
      p9_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_COEF: tcoef_r <= cfg_wdata[47:0];
        REG_PRES_LOW:  plow_r  <= cfg_wdata;
        REG_PRES_HIGH: phigh_r <= cfg_wdata;
        REG_PRES_NINE: p9_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic        [15:0] p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tcoef_r[15:0];
  assign t2 = $signed(tcoef_r[31:16]);
  assign t3 = $signed(tcoef_r[47:32]);
  assign p1 = plow_r[15:0];
  assign p2 = $signed(plow_r[31:16]);
  assign p3 = $signed(plow_r[47:32]);
  assign p4 = $signed(plow_r[63:48]);
  assign p5 = $signed(phigh_r[15:0]);
  assign p6 = $signed(phigh_r[31:16]);
  assign p7 = $signed(phigh_r[47:32]);
  assign p8 = $signed(phigh_r[63:48]);
  assign p9 = $signed(p9_r);

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic [11:0] vld_r;
  logic [5:0]  pst_vld_r;

  // stage 1
  logic signed [17:0] s1_a;
  logic signed [16:0] s1_d;
  logic signed [33:0] s1_at_nxt, s1_dd_nxt, s1_at_r;
  logic        [32:0] s1_dd_r;
  logic        [19:0] s1_adcp_r;
  assign s1_a = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign s1_d = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign s1_at_nxt = s1_a * t2;
  assign s1_dd_nxt = s1_d * s1_d;

  // stage 2
  logic signed [37:0] s2_p3_nxt, s2_p3_r;
  logic signed [22:0] s2_v1_r;
  logic        [19:0] s2_adcp_r;
  assign s2_p3_nxt = $signed({1'b0, s1_dd_r[32:12]}) * t3;

  // stage 3
  logic signed [24:0] s3_fine_nxt, s3_fine_r;
  logic        [19:0] s3_adcp_r;
  assign s3_fine_nxt = 25'(s2_v1_r) + 25'($signed(s2_p3_r[37:14]));

  // stage 4
  logic signed [25:0] s4_pv_nxt, s4_pv_r;
  logic signed [28:0] s4_f29, s4_t5;
  logic signed [20:0] s4_tcv;
  logic signed [15:0] s4_tout_nxt, s4_tout_r;
  logic        [19:0] s4_adcp_r;
  assign s4_pv_nxt = 26'(s3_fine_r) - 26'sd128000;
  assign s4_f29    = 29'(s3_fine_r);
  assign s4_t5     = (s4_f29 <<< 2) + s4_f29 + 29'sd128;
  assign s4_tcv    = s4_t5[28:8];
  always_comb begin
    if (s4_tcv < -21'sd32768) begin
      s4_tout_nxt = 16'sh8000;
    end else if (s4_tcv > 21'sd32767) begin
      s4_tout_nxt = 16'sh7FFF;
    end else begin
      s4_tout_nxt = s4_tcv[15:0];
    end
  end

  // stage 5
  logic signed [51:0] s5_sq_nxt;
  logic        [49:0] s5_sq_r;
  logic signed [41:0] s5_p5_nxt, s5_p2_nxt, s5_p5_r, s5_p2_r;
  logic signed [15:0] s5_tout_r;
  logic        [19:0] s5_adcp_r;
  assign s5_sq_nxt = s4_pv_r * s4_pv_r;
  assign s5_p5_nxt = s4_pv_r * p5;
  assign s5_p2_nxt = s4_pv_r * p2;

  // stage 6
  logic signed [48:0] s6_m6lo_nxt, s6_m3lo_nxt, s6_m6lo_r, s6_m3lo_r;
  logic signed [34:0] s6_m6hi_nxt, s6_m3hi_nxt, s6_m6hi_r, s6_m3hi_r;
  logic signed [41:0] s6_p5_r, s6_p2_r;
  logic signed [15:0] s6_tout_r;
  logic        [19:0] s6_adcp_r;
  assign s6_m6lo_nxt = $signed({1'b0, s5_sq_r[31:0]}) * p6;
  assign s6_m6hi_nxt = $signed({1'b0, s5_sq_r[49:32]}) * p6;
  assign s6_m3lo_nxt = $signed({1'b0, s5_sq_r[31:0]}) * p3;
  assign s6_m3hi_nxt = $signed({1'b0, s5_sq_r[49:32]}) * p3;

  // stage 7
  logic [63:0] s7_v2_nxt, s7_q3_nxt, s7_v2_r, s7_q3_r;
  logic signed [41:0] s7_p2_r;
  logic signed [15:0] s7_tout_r;
  logic        [19:0] s7_adcp_r;
  assign s7_v2_nxt = 64'(s6_m6lo_r) + {s6_m6hi_r[31:0], 32'b0}
                   + (64'(s6_p5_r) << 17) + (64'(p4) << 35);
  assign s7_q3_nxt = 64'(s6_m3lo_r) + {s6_m3hi_r[31:0], 32'b0};

  // stage 8
  logic [63:0] s8_x_nxt, s8_x_r, s8_v2_r;
  logic signed [15:0] s8_tout_r;
  logic        [19:0] s8_adcp_r;
  assign s8_x_nxt = {{8{s7_q3_r[63]}}, s7_q3_r[63:8]} + (64'(s7_p2_r) << 12)
                  + 64'h0000_8000_0000_0000;

  // stage 9
  logic        [47:0] s9_lo_nxt, s9_lo_r;
  logic signed [48:0] s9_hi_nxt, s9_hi_r;
  logic        [20:0] s9_pp;
  logic        [63:0] s9_dd_nxt, s9_dd_r;
  logic signed [15:0] s9_tout_r;
  assign s9_lo_nxt = s8_x_r[31:0] * p1;
  assign s9_hi_nxt = $signed(s8_x_r[63:32]) * $signed({1'b0, p1});
  assign s9_pp     = 21'h100000 - {1'b0, s8_adcp_r};
  assign s9_dd_nxt = {12'b0, s9_pp, 31'b0} - s8_v2_r;

  // stage 10
  logic        [63:0] s10_prod;
  logic signed [30:0] s10_v1_nxt, s10_v1_r;
  logic        [43:0] s10_mlo_nxt, s10_mlo_r;
  logic signed [44:0] s10_mhi_nxt, s10_mhi_r;
  logic signed [15:0] s10_tout_r;
  assign s10_prod    = 64'(s9_lo_r) + {s9_hi_r[31:0], 32'b0};
  assign s10_v1_nxt  = $signed(s10_prod[63:33]);
  assign s10_mlo_nxt = s9_dd_r[31:0] * 12'd3125;
  assign s10_mhi_nxt = $signed(s9_dd_r[63:32]) * $signed(13'd3125);

  // stage 11
  logic [63:0]       s11_dvd_nxt, s11_dvd_r;
  logic [DVS_W-1:0]  s11_mb_nxt, s11_mb_r;
  logic              s11_zero_r, s11_nb_r;
  logic signed [15:0] s11_tout_r;
  assign s11_dvd_nxt = 64'(s10_mlo_r) + {s10_mhi_r[31:0], 32'b0};
  assign s11_mb_nxt  = s10_v1_r[30] ? DVS_W'(-s10_v1_r) : DVS_W'(s10_v1_r);

  // stage 12
  logic [63:0]      s12_ma_r;
  logic [DVS_W-1:0] s12_mb_r;
  side_t            s12_side_r;

  // divider
  logic        div_vld;
  logic [63:0] div_quo;
  side_t       div_side;

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vld_r[11]),
    .in_dvd   (s12_ma_r),
    .in_dvs   (s12_mb_r),
    .in_side  (s12_side_r),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // stage 13
  logic [63:0] s13_p_r;
  side_t       s13_side_r;

  // stage 14
  logic signed [48:0] s14_m9lo_nxt, s14_m9lo_r, s14_p8lo_nxt, s14_p8lo_r;
  logic signed [34:0] s14_m9hi_nxt, s14_m9hi_r;
  logic signed [47:0] s14_p8hi_nxt, s14_p8hi_r;
  logic [63:0] s14_sx, s14_sx_r, s14_p_r;
  side_t       s14_side_r;
  assign s14_sx       = {{13{s13_p_r[63]}}, s13_p_r[63:13]};
  assign s14_m9lo_nxt = $signed({1'b0, s14_sx[31:0]}) * p9;
  assign s14_m9hi_nxt = $signed(s14_sx[50:32]) * p9;
  assign s14_p8lo_nxt = $signed({1'b0, s13_p_r[31:0]}) * p8;
  assign s14_p8hi_nxt = $signed(s13_p_r[63:32]) * p8;

  // stage 15
  logic [63:0] s15_m_nxt, s15_m_r, s15_pv8, s15_v2_nxt, s15_v2_r, s15_sx_r, s15_p_r;
  side_t       s15_side_r;
  assign s15_m_nxt  = 64'(s14_m9lo_r) + {s14_m9hi_r[31:0], 32'b0};
  assign s15_pv8    = 64'(s14_p8lo_r) + {s14_p8hi_r[31:0], 32'b0};
  assign s15_v2_nxt = {{19{s15_pv8[63]}}, s15_pv8[63:19]};

  // stage 16
  logic [63:0] s16_ll_nxt, s16_ll_r, s16_v2_r, s16_p_r;
  logic [31:0] s16_c1_nxt, s16_c2_nxt, s16_c1_r, s16_c2_r;
  side_t       s16_side_r;
  assign s16_ll_nxt = 64'(s15_m_r[31:0]) * 64'(s15_sx_r[31:0]);
  assign s16_c1_nxt = s15_m_r[31:0] * s15_sx_r[63:32];
  assign s16_c2_nxt = s15_m_r[63:32] * s15_sx_r[31:0];

  // stage 17
  logic [63:0] s17_prod, s17_v1_nxt, s17_v1_r, s17_v2_r, s17_p_r;
  side_t       s17_side_r;
  assign s17_prod   = s16_ll_r + {s16_c1_r + s16_c2_r, 32'b0};
  assign s17_v1_nxt = {{25{s17_prod[63]}}, s17_prod[63:25]};

  // stage 18
  logic [63:0] s18_sum_nxt, s18_sum_r;
  side_t       s18_side_r;
  assign s18_sum_nxt = s17_p_r + s17_v1_r + s17_v2_r;

  // output stage
  logic [63:0] fin_r64;
  logic [31:0] out_press_nxt, out_press_r;
  logic signed [15:0] out_temp_r;
  logic        out_err_r;
  assign fin_r64 = {{8{s18_sum_r[63]}}, s18_sum_r[63:8]} + (64'(p7) << 4);
  always_comb begin
    if (s18_side_r.zero || fin_r64[63]) begin
      out_press_nxt = '0;
    end else if (fin_r64[63:32] != 32'd0) begin
      out_press_nxt = 32'hFFFF_FFFF;
    end else begin
      out_press_nxt = fin_r64[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      pst_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[10:0], in_valid};
      pst_vld_r   <= {pst_vld_r[4:0], div_vld};
      out_valid_r <= pst_vld_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_at_r   <= s1_at_nxt;
      s1_dd_r   <= s1_dd_nxt[32:0];
      s1_adcp_r <= in_raw_pressure;

      s2_p3_r   <= s2_p3_nxt;
      s2_v1_r   <= s1_at_r[33:11];
      s2_adcp_r <= s1_adcp_r;

      s3_fine_r <= s3_fine_nxt;
      s3_adcp_r <= s2_adcp_r;

      s4_pv_r   <= s4_pv_nxt;
      s4_tout_r <= s4_tout_nxt;
      s4_adcp_r <= s3_adcp_r;

      s5_sq_r   <= s5_sq_nxt[49:0];
      s5_p5_r   <= s5_p5_nxt;
      s5_p2_r   <= s5_p2_nxt;
      s5_tout_r <= s4_tout_r;
      s5_adcp_r <= s4_adcp_r;

      s6_m6lo_r <= s6_m6lo_nxt;
      s6_m6hi_r <= s6_m6hi_nxt;
      s6_m3lo_r <= s6_m3lo_nxt;
      s6_m3hi_r <= s6_m3hi_nxt;
      s6_p5_r   <= s5_p5_r;
      s6_p2_r   <= s5_p2_r;
      s6_tout_r <= s5_tout_r;
      s6_adcp_r <= s5_adcp_r;

      s7_v2_r   <= s7_v2_nxt;
      s7_q3_r   <= s7_q3_nxt;
      s7_p2_r   <= s6_p2_r;
      s7_tout_r <= s6_tout_r;
      s7_adcp_r <= s6_adcp_r;

      s8_x_r    <= s8_x_nxt;
      s8_v2_r   <= s7_v2_r;
      s8_tout_r <= s7_tout_r;
      s8_adcp_r <= s7_adcp_r;

      s9_lo_r   <= s9_lo_nxt;
      s9_hi_r   <= s9_hi_nxt;
      s9_dd_r   <= s9_dd_nxt;
      s9_tout_r <= s8_tout_r;

      s10_v1_r   <= s10_v1_nxt;
      s10_mlo_r  <= s10_mlo_nxt;
      s10_mhi_r  <= s10_mhi_nxt;
      s10_tout_r <= s9_tout_r;

      s11_dvd_r  <= s11_dvd_nxt;
      s11_mb_r   <= s11_mb_nxt;
      s11_zero_r <= (s10_v1_r == 31'sd0);
      s11_nb_r   <= s10_v1_r[30];
      s11_tout_r <= s10_tout_r;

      s12_ma_r        <= s11_dvd_r[63] ? (64'd0 - s11_dvd_r) : s11_dvd_r;
      s12_mb_r        <= s11_mb_r;
      s12_side_r.tout <= s11_tout_r;
      s12_side_r.zero <= s11_zero_r;
      s12_side_r.neg  <= s11_dvd_r[63] ^ s11_nb_r;

      s13_p_r    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
      s13_side_r <= div_side;

      s14_m9lo_r <= s14_m9lo_nxt;
      s14_m9hi_r <= s14_m9hi_nxt;
      s14_p8lo_r <= s14_p8lo_nxt;
      s14_p8hi_r <= s14_p8hi_nxt;
      s14_sx_r   <= s14_sx;
      s14_p_r    <= s13_p_r;
      s14_side_r <= s13_side_r;

      s15_m_r    <= s15_m_nxt;
      s15_v2_r   <= s15_v2_nxt;
      s15_sx_r   <= s14_sx_r;
      s15_p_r    <= s14_p_r;
      s15_side_r <= s14_side_r;

      s16_ll_r   <= s16_ll_nxt;
      s16_c1_r   <= s16_c1_nxt;
      s16_c2_r   <= s16_c2_nxt;
      s16_v2_r   <= s15_v2_r;
      s16_p_r    <= s15_p_r;
      s16_side_r <= s15_side_r;

      s17_v1_r   <= s17_v1_nxt;
      s17_v2_r   <= s16_v2_r;
      s17_p_r    <= s16_p_r;
      s17_side_r <= s16_side_r;

      s18_sum_r  <= s18_sum_nxt;
      s18_side_r <= s17_side_r;

      out_press_r <= out_press_nxt;
      out_temp_r  <= s18_side_r.tout;
      out_err_r   <= s18_side_r.zero;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_q24_8    = out_press_r;
  assign out_divide_error      = out_err_r;

endmodule
